// File: src/assert_macros.svh
// Assertion macros used by the reorder buffer top level.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that must hold at every clock edge outside reset.
`define SRB_ASSERT(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("sequence reorder buffer check failed");

// Condition that must never be seen outside reset.
`define SRB_ASSERT_NEVER(label, clk, rst_n, expr) \
    `SRB_ASSERT(label, clk, rst_n, !(expr))

`endif

// File: src/srb_pkg.sv
// Shared types and constants of the sequence reorder buffer.
`timescale 1ns / 1ps

package srb_pkg;

    localparam int WINDOW_DEF = 16;
    localparam int MIN_FRAME  = 12;

    typedef enum logic [2:0] {
        ST_DELIVERED = 3'd0,
        ST_HELD      = 3'd1,
        ST_LATE      = 3'd2,
        ST_BEYOND    = 3'd3,
        ST_SHORT     = 3'd4
    } t_status;

    typedef enum logic {
        S_IDLE,
        S_RELEASE
    } t_state;

    // Record as it leaves the front queue.
    typedef struct packed {
        logic        short_frame;
        logic [15:0] seq_index;
        logic [31:0] node_id;
        logic [15:0] text_buf;
        logic [31:0] text_pos;
        logic [15:0] text_length;
        logic        has_text;
        logic [15:0] payload_ref;
    } t_rec;

    // Record fields kept in the window store.
    typedef struct packed {
        logic [31:0] node_id;
        logic [15:0] text_buf;
        logic [31:0] text_pos;
        logic [15:0] text_length;
        logic        has_text;
        logic [15:0] payload_ref;
    } t_slot;

    // One result word.
    typedef struct packed {
        t_status     status;
        logic [15:0] out_seq;
        logic [31:0] out_node_id;
        logic [15:0] out_buffer_id;
        logic [31:0] out_pos;
        logic [15:0] out_length;
        logic        out_has_text;
        logic [15:0] out_payload_ref;
        logic        last;
    } t_res;

endpackage

// File: src/sequence_reorder_buffer.sv
// Top level of the sequence reorder buffer: front queue, back sequencer, checks.
//
//  Channel   Direction  Handshake                Word
//  in        input      i_in_valid / o_in_stall  frame length, sequence number, record fields
//  out       output     o_out_valid / i_out_stall status, record fields, last
//
// A record that is dropped, held or delivered alone gives a single result word; a
// delivery that frees a run of held records then releases them one by one, paced
// by the registered read of the window store.
// The front queue holds two words, so it takes up to two more words while a run drains.
// Reset is synchronous and clears the expected number and every slot valid bit.
// A stalled output holds its word and the back end waits; the queue then fills.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module sequence_reorder_buffer
    import srb_pkg::*;
#(
    parameter int WINDOW = WINDOW_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [10:0] i_frame_length,
    input  logic [15:0] i_seq_index,
    input  logic [31:0] i_node_id,
    input  logic [15:0] i_buffer_id,
    input  logic [31:0] i_text_pos,
    input  logic [15:0] i_text_length,
    input  logic        i_has_text,
    input  logic [15:0] i_payload_ref,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [2:0]  o_status,
    output logic [15:0] o_out_seq,
    output logic [31:0] o_out_node_id,
    output logic [15:0] o_out_buffer_id,
    output logic [31:0] o_out_pos,
    output logic [15:0] o_out_length,
    output logic        o_out_has_text,
    output logic [15:0] o_out_payload_ref,
    output logic        o_last
);

    logic q_valid;
    logic q_pop;
    t_rec q_rec;
    t_res res;

    srb_front u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_frame_length (i_frame_length),
        .i_seq_index    (i_seq_index),
        .i_node_id      (i_node_id),
        .i_buffer_id    (i_buffer_id),
        .i_text_pos     (i_text_pos),
        .i_text_length  (i_text_length),
        .i_has_text     (i_has_text),
        .i_payload_ref  (i_payload_ref),
        .o_q_valid      (q_valid),
        .o_q_rec        (q_rec),
        .i_q_pop        (q_pop)
    );

    srb_back #(
        .WINDOW (WINDOW)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_q_valid   (q_valid),
        .i_q_rec     (q_rec),
        .o_q_pop     (q_pop),
        .i_out_stall (i_out_stall),
        .o_out_valid (o_out_valid),
        .o_out       (res)
    );

    assign o_status          = res.status;
    assign o_out_seq         = res.out_seq;
    assign o_out_node_id     = res.out_node_id;
    assign o_out_buffer_id   = res.out_buffer_id;
    assign o_out_pos         = res.out_pos;
    assign o_out_length      = res.out_length;
    assign o_out_has_text    = res.out_has_text;
    assign o_out_payload_ref = res.out_payload_ref;
    assign o_last            = res.last;

    // The input only stalls when the queue holds words for the back end.
    `SRB_ASSERT(a_stall_needs_queue, i_clk, i_rst_n, o_in_stall |-> q_valid)
    // The back end never pops an empty queue.
    `SRB_ASSERT_NEVER(a_pop_empty, i_clk, i_rst_n, q_pop && !q_valid)
    // Anything but a delivery closes its record's results.
    `SRB_ASSERT(a_drop_is_last, i_clk, i_rst_n,
        (o_out_valid && (o_status != ST_DELIVERED)) |-> o_last)
    // A word without text carries no text handle.
    `SRB_ASSERT(a_no_text_no_ref, i_clk, i_rst_n,
        (o_out_valid && !o_out_has_text) |-> (o_out_payload_ref == 16'd0))

endmodule

// File: src/srb_front.sv
// Front end: two-word input queue that flags short frames.
`timescale 1ns / 1ps

module srb_front
    import srb_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [10:0] i_frame_length,
    input  logic [15:0] i_seq_index,
    input  logic [31:0] i_node_id,
    input  logic [15:0] i_buffer_id,
    input  logic [31:0] i_text_pos,
    input  logic [15:0] i_text_length,
    input  logic        i_has_text,
    input  logic [15:0] i_payload_ref,
    output logic        o_q_valid,
    output t_rec        o_q_rec,
    input  logic        i_q_pop
);

    t_rec        r_mem [2];
    logic        r_wr_ptr, n_wr_ptr;
    logic        r_rd_ptr, n_rd_ptr;
    logic [1:0]  r_count, n_count;
    logic        push;
    t_rec        in_rec;

    assign o_in_stall = (r_count == 2'd2);
    assign o_q_valid  = (r_count != 2'd0);
    assign o_q_rec    = r_mem[r_rd_ptr];
    assign push       = i_in_valid && !o_in_stall;

    always_comb begin
        in_rec.short_frame = (i_frame_length < 11'(MIN_FRAME));
        in_rec.seq_index   = i_seq_index;
        in_rec.node_id     = i_node_id;
        in_rec.text_buf    = i_buffer_id;
        in_rec.text_pos    = i_text_pos;
        in_rec.text_length = i_text_length;
        in_rec.has_text    = i_has_text;
        in_rec.payload_ref = i_payload_ref;
    end

    always_comb begin
        n_wr_ptr = push ? !r_wr_ptr : r_wr_ptr;
        n_rd_ptr = i_q_pop ? !r_rd_ptr : r_rd_ptr;
        n_count  = r_count;
        if (push && !i_q_pop) begin
            n_count = r_count + 2'd1;
        end else if (!push && i_q_pop) begin
            n_count = r_count - 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wr_ptr] <= in_rec;
        end
    end

endmodule

// File: src/srb_back.sv
// Back end: classifies queued records, holds early ones and releases runs in order.
`timescale 1ns / 1ps

module srb_back
    import srb_pkg::*;
#(
    parameter int WINDOW = WINDOW_DEF
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_q_valid,
    input  t_rec i_q_rec,
    output logic o_q_pop,
    input  logic i_out_stall,
    output logic o_out_valid,
    output t_res o_out
);

    localparam int              SW        = $clog2(WINDOW);
    localparam logic [SW-1:0]   LAST_SLOT = SW'(WINDOW - 1);
    localparam logic [SW-1:0]   LIMIT     = SW'(WINDOW - 2);
    localparam logic [SW:0]     WIN_EXT   = (SW + 1)'(WINDOW);

    t_state              r_state, n_state;
    logic [15:0]         r_exp, n_exp;
    logic [SW-1:0]       r_exp_slot, n_exp_slot;
    logic [WINDOW-1:0]   r_valid, n_valid;
    logic [SW-1:0]       r_count, n_count;
    logic                r_out_valid, n_out_valid;
    t_res                r_out, n_out;

    t_slot               r_mem [WINDOW];
    t_slot               r_rd;
    t_slot               wr_data;
    logic                mem_we;
    logic                rd_en;
    logic [SW-1:0]       rd_addr;

    logic                out_free;
    logic [15:0]         diff;
    logic [16:0]         seq_sum;
    logic [SW:0]         slot_sum;
    logic [SW-1:0]       hold_slot;
    logic [SW-1:0]       nxt_slot;
    logic                is_late, is_beyond, is_held, is_deliver;
    logic                take;
    logic                run_first;
    logic                run_more;

    assign out_free = !r_out_valid || !i_out_stall;

    // Classification and slot arithmetic; the slot of the incoming number
    // follows from the expected slot because the distance stays below WINDOW.
    always_comb begin
        diff       = i_q_rec.seq_index - r_exp;
        is_late    = diff[15];
        is_beyond  = !is_late && (diff >= 16'(WINDOW));
        is_held    = !is_late && !is_beyond && (diff != 16'd0);
        is_deliver = (diff == 16'd0);
        seq_sum    = {1'b0, r_exp} + {1'b0, diff};
        slot_sum   = {1'b0, r_exp_slot} + {1'b0, diff[SW-1:0]};
        if (seq_sum[16]) begin
            // The number wrapped past zero, so it is below WINDOW itself.
            hold_slot = i_q_rec.seq_index[SW-1:0];
        end else if (slot_sum >= WIN_EXT) begin
            hold_slot = SW'(slot_sum - WIN_EXT);
        end else begin
            hold_slot = slot_sum[SW-1:0];
        end
        if ((r_exp == 16'hFFFF) || (r_exp_slot == LAST_SLOT)) begin
            nxt_slot = '0;
        end else begin
            nxt_slot = r_exp_slot + 1'b1;
        end
        take      = (r_state == S_IDLE) && i_q_valid && out_free;
        run_first = !i_q_rec.short_frame && is_deliver && r_valid[nxt_slot];
        // The slot being released now is cleared, so it cannot extend the run.
        run_more  = r_valid[nxt_slot] && (nxt_slot != r_exp_slot) && (r_count < LIMIT);
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (take && run_first) begin
                    n_state = S_RELEASE;
                end
            end
            S_RELEASE: begin
                if (out_free && !run_more) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        n_exp       = r_exp;
        n_exp_slot  = r_exp_slot;
        n_valid     = r_valid;
        n_count     = r_count;
        n_out       = r_out;
        n_out_valid = r_out_valid && i_out_stall;
        o_q_pop     = 1'b0;
        mem_we      = 1'b0;
        rd_en       = 1'b0;
        rd_addr     = nxt_slot;
        wr_data.node_id     = i_q_rec.node_id;
        wr_data.text_buf    = i_q_rec.text_buf;
        wr_data.text_pos    = i_q_rec.text_pos;
        wr_data.text_length = i_q_rec.text_length;
        wr_data.has_text    = i_q_rec.has_text;
        wr_data.payload_ref = i_q_rec.payload_ref;
        case (r_state)
            S_IDLE: begin
                if (take) begin
                    o_q_pop         = 1'b1;
                    n_out_valid     = 1'b1;
                    n_out           = '0;
                    n_out.out_seq   = i_q_rec.seq_index;
                    n_out.last      = 1'b1;
                    if (i_q_rec.short_frame) begin
                        n_out.status = ST_SHORT;
                    end else if (is_late) begin
                        n_out.status = ST_LATE;
                    end else if (is_beyond) begin
                        n_out.status = ST_BEYOND;
                    end else if (is_held) begin
                        n_out.status       = ST_HELD;
                        mem_we             = 1'b1;
                        n_valid[hold_slot] = 1'b1;
                    end else begin
                        n_out.status          = ST_DELIVERED;
                        n_out.out_node_id     = i_q_rec.node_id;
                        n_out.out_buffer_id   = i_q_rec.text_buf;
                        n_out.out_pos         = i_q_rec.text_pos;
                        n_out.out_length      = i_q_rec.text_length;
                        n_out.out_has_text    = i_q_rec.has_text;
                        n_out.out_payload_ref = i_q_rec.has_text ? i_q_rec.payload_ref : 16'd0;
                        n_out.last            = !run_first;
                        n_exp                 = r_exp + 16'd1;
                        n_exp_slot            = nxt_slot;
                        n_count               = '0;
                        rd_en                 = run_first;
                    end
                end
            end
            S_RELEASE: begin
                if (out_free) begin
                    n_out_valid           = 1'b1;
                    n_out.status          = ST_DELIVERED;
                    n_out.out_seq         = r_exp;
                    n_out.out_node_id     = r_rd.node_id;
                    n_out.out_buffer_id   = r_rd.text_buf;
                    n_out.out_pos         = r_rd.text_pos;
                    n_out.out_length      = r_rd.text_length;
                    n_out.out_has_text    = r_rd.has_text;
                    n_out.out_payload_ref = r_rd.has_text ? r_rd.payload_ref : 16'd0;
                    n_out.last            = !run_more;
                    n_valid[r_exp_slot]   = 1'b0;
                    n_exp                 = r_exp + 16'd1;
                    n_exp_slot            = nxt_slot;
                    n_count               = r_count + 1'b1;
                    rd_en                 = run_more;
                end
            end
            default: begin
                n_out_valid = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_exp       <= 16'd0;
            r_exp_slot  <= '0;
            r_valid     <= '0;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_exp       <= n_exp;
            r_exp_slot  <= n_exp_slot;
            r_valid     <= n_valid;
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out <= n_out;
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[hold_slot] <= wr_data;
        end
        if (rd_en) begin
            r_rd <= r_mem[rd_addr];
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

endmodule
